// ----- sv/idea_pkg.sv -----
// Shared types, constants and arithmetic helpers for the IDEA cipher block.
// No dependencies; imported by the key schedule, the round and the top level.
`default_nettype none
package idea_pkg;

	localparam int ROUNDS = 8;
	localparam int NSUB = 6 * ROUNDS + 4;
	localparam int NINV = 2 * (ROUNDS + 1);
	localparam int INV_IDX_W = $clog2(NINV);
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW = 2'd1;

	typedef logic [15:0] word_t;
	typedef word_t [NSUB-1:0] keyset_t;
	typedef word_t [NINV-1:0] invset_t;
	typedef word_t [5:0] rkey_t;
	typedef word_t [3:0] okey_t;

	typedef struct packed {
		logic valid;
		logic kind;
		logic [63:0] blk;
	} pkt_t;

	// Multiply mod 65537, word 0 standing for 65536
	function automatic word_t mulm(word_t a, word_t b);
		logic [31:0] p;
		word_t lo;
		word_t hi;
		word_t r;
		p = 32'(a) * 32'(b);
		lo = p[15:0];
		hi = p[31:16];
		if (a == 16'd0) begin
			r = 16'd1 - b;
		end else if (b == 16'd0) begin
			r = 16'd1 - a;
		end else begin
			r = lo - hi + {15'd0, (lo < hi)};
		end
		return r;
	endfunction

	// Encryption subkeys: 25-bit left rotations of the key, eight words each
	function automatic keyset_t enc_keys(logic [127:0] key);
		keyset_t k;
		logic [127:0] rk;
		int rot;
		for (int i = 0; i < NSUB; i++) begin
			rot = (25 * (i >> 3)) & 127;
			rk = (key << rot) | (key >> (128 - rot));
			k[i] = rk[127 - 16 * (i & 7) -: 16];
		end
		return k;
	endfunction

	// Decryption subkeys: inverses in reverse order, additive ones negated likewise
	function automatic keyset_t dec_keys(keyset_t e, invset_t v);
		keyset_t d;
		for (int m = 0; m <= ROUNDS; m++) begin
			d[6*m] = v[2*m];
			d[6*m+3] = v[2*m+1];
			if (m == 0 || m == ROUNDS) begin
				d[6*m+1] = 16'd0 - e[6*(ROUNDS-m)+1];
				d[6*m+2] = 16'd0 - e[6*(ROUNDS-m)+2];
			end else begin
				d[6*m+1] = 16'd0 - e[6*(ROUNDS-m)+2];
				d[6*m+2] = 16'd0 - e[6*(ROUNDS-m)+1];
			end
			if (m < ROUNDS) begin
				d[6*m+4] = e[6*(ROUNDS-1-m)+4];
				d[6*m+5] = e[6*(ROUNDS-1-m)+5];
			end
		end
		return d;
	endfunction

endpackage
`default_nettype wire

// ----- sv/idea_block_cipher_top.sv -----
// IDEA cipher, ECB. One block per cycle while busy is low; done pulses once per
// accepted block after three stages per round times eight rounds plus the
// output transform stage. A key write holds busy while the shared inverse
// multiplier derives the decryption subkeys. Reset clears the key to zero
// with valid subkeys at once. Results cannot be stalled by the receiver.
`default_nettype none
module idea_block_cipher_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic                           kind,
	input  wire logic [63:0]                    block_in,
	output logic                                done,
	output logic [63:0]                         block_out,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [idea_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]                    cfg_data
);
	import idea_pkg::*;

	keyset_t enc, dec;
	pkt_t pkt [ROUNDS+1];
	pkt_t last;
	okey_t z;
	logic done_q;
	logic [63:0] block_out_q;

	idea_ksched u_ksched (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.enc(enc),
		.dec(dec),
		.busy(busy)
	);

	assign pkt[0] = '{valid: start && !busy, kind: kind, blk: block_in};

	// Round chain
	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		idea_mix_stage u_round (
			.clk(clk),
			.arst_n(arst_n),
			.in_pkt(pkt[r]),
			.enc_k(enc[6*r+5 : 6*r]),
			.dec_k(dec[6*r+5 : 6*r]),
			.out_pkt(pkt[r+1])
		);
	end

	assign last = pkt[ROUNDS];
	assign z = last.kind ? dec[NSUB-1 : 6*ROUNDS] : enc[NSUB-1 : 6*ROUNDS];

	// Output transform; middle swap undone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		block_out_q <= {mulm(last.blk[63:48], z[0]), last.blk[31:16] + z[1],
			last.blk[47:32] + z[2], mulm(last.blk[15:0], z[3])};
	end

	assign done = done_q;
	assign block_out = block_out_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 25))
		else $error("result without matching request");

	a_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW))
		|=> busy)
		else $error("key write did not start subkey rebuild");

	a_no_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cfg_ready)
		else $error("key request taken during rebuild");

endmodule
`default_nettype wire

// ----- sv/idea_ksched.sv -----
// Key registers and subkey schedule; multiplicative inverses by a shared
// square-and-multiply sequencer. Depends on idea_pkg.
`default_nettype none
module idea_ksched (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [idea_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]                    cfg_data,
	output idea_pkg::keyset_t                   enc,
	output idea_pkg::keyset_t                   dec,
	output logic                                busy
);
	import idea_pkg::*;

	logic [63:0] key_high_q;
	logic [63:0] key_low_q;
	invset_t inv_q;
	logic busy_q;
	logic ld_q;
	logic ph_q;
	logic [3:0] step_q;
	logic [INV_IDX_W-1:0] slot_q;
	word_t base_q;
	word_t acc_q;
	word_t src;
	word_t prod;
	logic wr;

	assign enc = enc_keys({key_high_q, key_low_q});
	assign dec = dec_keys(enc, inv_q);
	assign busy = busy_q;
	assign cfg_ready = !busy_q;
	assign wr = cfg_valid && cfg_ready &&
		(cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW);

	// Source word of the current inverse slot
	always_comb begin
		src = enc[6 * (ROUNDS - int'(slot_q >> 1)) + 3 * int'(slot_q[0])];
	end

	// One shared modular multiplier: square, then multiply by the base
	assign prod = mulm(acc_q, ph_q ? base_q : acc_q);

	// Take a key request and run the inverse sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			inv_q <= '0;
			busy_q <= 1'b0;
			ld_q <= 1'b0;
			ph_q <= 1'b0;
			step_q <= '0;
			slot_q <= '0;
		end else if (wr) begin
			if (cfg_index == CFG_KEY_HIGH) begin
				key_high_q <= cfg_data;
			end else begin
				key_low_q <= cfg_data;
			end
			busy_q <= 1'b1;
			ld_q <= 1'b1;
			ph_q <= 1'b0;
			step_q <= '0;
			slot_q <= '0;
		end else if (busy_q) begin
			if (ld_q) begin
				ld_q <= 1'b0;
			end else if (!ph_q) begin
				ph_q <= 1'b1;
			end else begin
				ph_q <= 1'b0;
				if (step_q == 4'd14) begin
					inv_q[slot_q] <= prod;
					step_q <= '0;
					if (slot_q == INV_IDX_W'(NINV - 1)) begin
						busy_q <= 1'b0;
					end else begin
						slot_q <= slot_q + 1'b1;
						ld_q <= 1'b1;
					end
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	// Load the base, then hold the running power
	always_ff @(posedge clk) begin
		if (ld_q) begin
			base_q <= src;
			acc_q <= src;
		end else if (busy_q) begin
			acc_q <= prod;
		end
	end

endmodule
`default_nettype wire

// ----- sv/idea_round.sv -----
// One IDEA round in three register stages; subkeys picked per stage by kind.
// Depends on idea_pkg.
`default_nettype none
module idea_mix_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire idea_pkg::pkt_t  in_pkt,
	input  wire idea_pkg::rkey_t enc_k,
	input  wire idea_pkg::rkey_t dec_k,
	output idea_pkg::pkt_t       out_pkt
);
	import idea_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic kind_s1, kind_s2, kind_s3;
	word_t a_s1, b_s1, c_s1, d_s1;
	word_t a_s2, b_s2, c_s2, d_s2, m1_s2;
	logic [63:0] blk_s3;
	rkey_t k0, k1, k2;
	word_t a_in, b_in, c_in, d_in;
	word_t m2, m1b;

	assign k0 = in_pkt.kind ? dec_k : enc_k;
	assign k1 = kind_s1 ? dec_k : enc_k;
	assign k2 = kind_s2 ? dec_k : enc_k;
	assign a_in = in_pkt.blk[63:48];
	assign b_in = in_pkt.blk[47:32];
	assign c_in = in_pkt.blk[31:16];
	assign d_in = in_pkt.blk[15:0];
	assign m2 = mulm((b_s2 ^ d_s2) + m1_s2, k2[5]);
	assign m1b = m1_s2 + m2;

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_pkt.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Key mix, MA multiply one, MA multiply two with output mix and swap
	always_ff @(posedge clk) begin
		kind_s1 <= in_pkt.kind;
		a_s1 <= mulm(a_in, k0[0]);
		b_s1 <= b_in + k0[1];
		c_s1 <= c_in + k0[2];
		d_s1 <= mulm(d_in, k0[3]);
		kind_s2 <= kind_s1;
		a_s2 <= a_s1;
		b_s2 <= b_s1;
		c_s2 <= c_s1;
		d_s2 <= d_s1;
		m1_s2 <= mulm(a_s1 ^ c_s1, k1[4]);
		kind_s3 <= kind_s2;
		blk_s3 <= {a_s2 ^ m2, c_s2 ^ m2, b_s2 ^ m1b, d_s2 ^ m1b};
	end

	assign out_pkt = '{valid: v_s3, kind: kind_s3, blk: blk_s3};

endmodule
`default_nettype wire
